// ===== rtl/clsce_pkg.sv =====
// Shared types and constants of the canvas line, square and copy engine.
package clsce_pkg;

    typedef enum logic [2:0] {
        OP_LINE   = 3'd0,
        OP_SQUARE = 3'd1,
        OP_SHADE  = 3'd2,
        OP_COPY   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CMD_DRAW = 2'd0,
        CMD_COPY = 2'd1,
        CMD_READ = 2'd2
    } cmd_kind_t;

    localparam logic [2:0] SHADE_WHITE = 3'd4;

    // One classified command, as handed from the front end to the back end.
    typedef struct packed {
        cmd_kind_t   kind;
        logic        two_d;      // square region rather than a line
        logic        rd_on;      // read coordinates lie on the canvas
        logic [6:0]  row;
        logic [6:0]  col;
        logic [6:0]  trow;
        logic [6:0]  tcol;
        logic signed [1:0] dr;
        logic signed [1:0] dc;
        logic [7:0]  len;        // 1..128
        logic [2:0]  shade;      // shade in force when the command was taken
    } cmd_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_CLEAR,
        BK_READ,
        BK_READ_WAIT,
        BK_COPY_RD,
        BK_COPY_WR,
        BK_WRITE,
        BK_OUT
    } bk_state_t;

endpackage

// ===== rtl/canvas_line_square_copy_engine_unit.sv =====
// Top level of the canvas line, square and copy engine.
// The engine keeps a ROWS by COLS canvas of 3-bit shades in one on-chip memory and
// a current shade. A front end takes each beat while the queue has room, works out
// heading and bounds and queues up to four accepted commands; the back end takes
// each command from the queue in its idle state and then carries it out through the
// single memory port: a draw writes one pixel each cycle (len pixels, or len*len for
// a diagonal square), a copy reads and then writes each pixel, and a read passes
// through BK_READ, BK_READ_WAIT and BK_OUT, holding BK_OUT until the result is taken.
// After reset the back end paints the whole canvas white; commands queue meanwhile.
// Shade changes and rejected commands stay in the front end and are never queued.
module canvas_line_square_copy_engine_unit
    import clsce_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[2:0], org_row[9:3], org_col[16:10], length[24:17],
    // direction[35:25], dst_row[42:36], dst_col[49:43], shade_change[53:50]
    input  logic [55:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_value[2:0], in_range[3]
    output logic [7:0]  m_tdata
);

    cmd_t q_in, q_out;
    logic q_push, q_full, q_pop, q_empty, busy;
    logic [2:0] pixel_value;
    logic in_range;

    clsce_front #(.ROWS(ROWS), .COLS(COLS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .operation(s_tdata[2:0]), .org_row(s_tdata[9:3]),
        .org_col(s_tdata[16:10]), .length(s_tdata[24:17]),
        .direction(s_tdata[35:25]), .dst_row(s_tdata[42:36]),
        .dst_col(s_tdata[49:43]), .shade_change(s_tdata[53:50]),
        .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    clsce_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .pop_data(q_out)
    );

    clsce_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .pixel_value(pixel_value), .in_range(in_range), .busy(busy)
    );

    assign m_tdata = {4'b0000, in_range, pixel_value};

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full) else $error("command pushed into full queue");

    // A result only appears while the back end is working.
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> busy) else $error("result beat while back end idle");

    // A read off the canvas returns black.
    a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !in_range) |-> (pixel_value == 3'd0))
        else $error("off-canvas read returned a shade");

endmodule

// ===== rtl/clsce_front.sv =====
// Front end: takes commands, resolves heading and bounds, keeps the current shade.
module clsce_front
    import clsce_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  operation,
    input  logic [6:0]  org_row,
    input  logic [6:0]  org_col,
    input  logic signed [7:0]  length,
    input  logic signed [10:0] direction,
    input  logic [6:0]  dst_row,
    input  logic [6:0]  dst_col,
    input  logic signed [3:0]  shade_change,
    output logic        q_push,
    output cmd_t        q_data,
    input  logic        q_full
);

    logic [2:0]         shade_reg, shade_next;
    logic signed [11:0] d_adj;
    logic [8:0]         rem_mag;
    logic [11:0]        d_abs;
    logic               d_neg;
    logic [7:0]         len_abs;
    logic               hd_ok, hd_diag, axis;
    logic signed [1:0]  dr, dc;
    logic signed [9:0]  er, ec, etr, etc_;
    logic               start_on, targ_on, end_on, tend_on;
    logic signed [4:0]  s_sum;
    logic               accept;
    logic               issue;
    op_t                op;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign op       = op_t'(operation);

    always_comb
    begin
        len_abs = length[7] ? 8'(-length) : 8'(length);
        d_adj   = 12'(direction) + (length[7] ? 12'sd180 : 12'sd0);
        d_neg   = d_adj[11];
        d_abs   = d_neg ? 12'(-d_adj) : 12'(d_adj);
        // Magnitude below 1204, so at most three subtractions of 360.
        rem_mag = 9'(d_abs >= 12'd1080 ? d_abs - 12'd1080 :
                     d_abs >= 12'd720  ? d_abs - 12'd720  :
                     d_abs >= 12'd360  ? d_abs - 12'd360  : d_abs);
        axis = (rem_mag == 9'd0) || (rem_mag == 9'd90) || (rem_mag == 9'd180) ||
               (rem_mag == 9'd270);
        hd_ok   = 1'b1;
        hd_diag = 1'b0;
        dr      = 2'sd0;
        dc      = 2'sd0;
        if (d_neg && rem_mag != 9'd0)
        begin
            hd_ok = 1'b0;
        end
        else
        begin
            case (rem_mag)
                9'd0:   begin dr = -2'sd1; end
                9'd90:  begin dc = 2'sd1; end
                9'd180: begin dr = 2'sd1; end
                9'd270: begin dc = -2'sd1; end
                9'd45:  begin dr = -2'sd1; dc = 2'sd1;  hd_diag = 1'b1; end
                9'd135: begin dr = 2'sd1;  dc = 2'sd1;  hd_diag = 1'b1; end
                9'd225: begin dr = 2'sd1;  dc = -2'sd1; hd_diag = 1'b1; end
                9'd315: begin dr = -2'sd1; dc = -2'sd1; hd_diag = 1'b1; end
                default: hd_ok = 1'b0;
            endcase
        end
        er   = 10'(org_row) + ((dr == 2'sd0) ? 10'sd0 :
               (dr[1] ? -10'(len_abs - 8'd1) : 10'(len_abs - 8'd1)));
        ec   = 10'(org_col) + ((dc == 2'sd0) ? 10'sd0 :
               (dc[1] ? -10'(len_abs - 8'd1) : 10'(len_abs - 8'd1)));
        etr  = 10'(dst_row) + ((dr == 2'sd0) ? 10'sd0 :
               (dr[1] ? -10'(len_abs - 8'd1) : 10'(len_abs - 8'd1)));
        etc_ = 10'(dst_col) + ((dc == 2'sd0) ? 10'sd0 :
               (dc[1] ? -10'(len_abs - 8'd1) : 10'(len_abs - 8'd1)));
        start_on = (32'(org_row) < ROWS) && (32'(org_col) < COLS);
        targ_on  = (32'(dst_row) < ROWS) && (32'(dst_col) < COLS);
        end_on   = !er[9] && !ec[9] && (32'(er) < ROWS) && (32'(ec) < COLS);
        tend_on  = !etr[9] && !etc_[9] && (32'(etr) < ROWS) && (32'(etc_) < COLS);
        s_sum    = 5'(signed'({2'b00, shade_reg})) + 5'(shade_change);
    end

    always_comb
    begin
        shade_next = shade_reg;
        issue      = 1'b0;
        q_data       = '0;
        q_data.kind  = CMD_DRAW;
        q_data.row   = org_row;
        q_data.col   = org_col;
        q_data.trow  = dst_row;
        q_data.tcol  = dst_col;
        q_data.dr    = dr;
        q_data.dc    = dc;
        q_data.len   = len_abs;
        q_data.shade = shade_reg;
        q_data.rd_on = start_on;
        case (op)
            OP_LINE:
            begin
                issue = hd_ok && start_on && end_on && len_abs != 8'd0;
            end
            OP_SQUARE:
            begin
                q_data.two_d = hd_diag;
                issue = hd_ok && start_on && end_on && len_abs != 8'd0;
            end
            OP_COPY:
            begin
                q_data.kind  = CMD_COPY;
                q_data.two_d = hd_diag;
                issue = hd_ok && start_on && end_on && targ_on && tend_on &&
                        len_abs != 8'd0;
            end
            OP_READ:
            begin
                q_data.kind = CMD_READ;
                issue = 1'b1;
            end
            OP_SHADE:
            begin
                if (!s_sum[4] && s_sum <= 5'sd4)
                begin
                    shade_next = s_sum[2:0];
                end
            end
            default: issue = 1'b0;
        endcase
        // A square needs a diagonal heading unless it falls back to a line.
        if (op == OP_SQUARE && !hd_diag && !axis)
        begin
            issue = 1'b0;
        end
        q_push = accept && issue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shade_reg <= 3'd0;
        end
        else if (accept)
        begin
            shade_reg <= shade_next;
        end
    end

endmodule

// ===== rtl/clsce_queue.sv =====
// Short command queue between the front end and the back end.
module clsce_queue
    import clsce_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_data
);

    localparam int DEPTH = 4;

    cmd_t       mem_reg [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full     = (cnt_reg == 3'(DEPTH));
    assign empty    = (cnt_reg == 3'd0);
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop && !empty)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(push && !full) - 3'(pop && !empty);
        end
    end

endmodule

// ===== rtl/clsce_back.sv =====
// Back end: clears the canvas after reset and carries out draws, copies and reads.
module clsce_back
    import clsce_pkg::*;
#(
    parameter int ROWS = 32,
    parameter int COLS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  cmd_t       q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [2:0] pixel_value,
    output logic       in_range,
    output logic       busy
);

    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [2:0]  mem [DEPTH];
    bk_state_t   state_reg, state_next;
    cmd_t        cmd_reg;
    logic [AW:0] clr_reg;
    logic [7:0]  i_reg, j_reg;
    logic [2:0]  rdata_reg;
    logic [2:0]  pix_reg;
    logic        rng_reg;
    logic        we, re, last;
    logic [AW-1:0] waddr, raddr;
    logic [2:0]  wdata;
    logic signed [9:0] sr, sc, tr, tc;

    function automatic logic signed [9:0] off(input logic [6:0] b,
                                              input logic signed [1:0] s,
                                              input logic [7:0] k);
        logic signed [9:0] r;
        begin
            r = 10'(b);
            if (s == 2'sd1)
                r = r + 10'(k);
            else if (s == -2'sd1)
                r = r - 10'(k);
            return r;
        end
    endfunction

    always_comb
    begin
        sr = off(cmd_reg.row,  cmd_reg.dr, i_reg);
        sc = off(cmd_reg.col,  cmd_reg.dc, cmd_reg.two_d ? j_reg : i_reg);
        tr = off(cmd_reg.trow, cmd_reg.dr, i_reg);
        tc = off(cmd_reg.tcol, cmd_reg.dc, cmd_reg.two_d ? j_reg : i_reg);
        raddr = (state_reg == BK_READ) ? AW'(32'(cmd_reg.row) * COLS + 32'(cmd_reg.col))
                                       : AW'(32'(sr) * COLS + 32'(sc));
        last = cmd_reg.two_d ? (i_reg == cmd_reg.len - 8'd1 && j_reg == cmd_reg.len - 8'd1)
                             : (i_reg == cmd_reg.len - 8'd1);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_CLEAR:     if (clr_reg == (AW+1)'(DEPTH - 1)) state_next = BK_IDLE;
            BK_IDLE:
                if (!q_empty)
                begin
                    case (q_data.kind)
                        CMD_READ: state_next = BK_READ;
                        CMD_COPY: state_next = BK_COPY_RD;
                        default:  state_next = BK_WRITE;
                    endcase
                end
            BK_READ:      state_next = BK_READ_WAIT;
            BK_READ_WAIT: state_next = BK_OUT;
            BK_OUT:       if (out_ready) state_next = BK_IDLE;
            BK_COPY_RD:   state_next = BK_COPY_WR;
            BK_COPY_WR:   state_next = last ? BK_IDLE : BK_COPY_RD;
            BK_WRITE:     if (last) state_next = BK_IDLE;
            default:      state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop = (state_reg == BK_IDLE) && !q_empty;
        we    = 1'b0;
        re    = 1'b0;
        waddr = AW'(32'(tr) * COLS + 32'(tc));
        wdata = cmd_reg.shade;
        case (state_reg)
            BK_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg[AW-1:0];
                wdata = SHADE_WHITE;
            end
            BK_WRITE:
            begin
                we    = 1'b1;
                waddr = AW'(32'(sr) * COLS + 32'(sc));
            end
            BK_READ:    re = 1'b1;
            BK_COPY_RD: re = 1'b1;
            BK_COPY_WR:
            begin
                we    = 1'b1;
                wdata = rdata_reg;
            end
            default: we = 1'b0;
        endcase
        out_valid   = (state_reg == BK_OUT);
        pixel_value = pix_reg;
        in_range    = rng_reg;
        busy        = (state_reg != BK_IDLE) || !q_empty;
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
        if (q_pop)
            cmd_reg <= q_data;
        if (state_reg == BK_READ_WAIT)
        begin
            pix_reg <= cmd_reg.rd_on ? rdata_reg : 3'd0;
            rng_reg <= cmd_reg.rd_on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_CLEAR;
            clr_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_CLEAR)
                clr_reg <= clr_reg + (AW+1)'(1);
            if (q_pop)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else if (state_reg == BK_WRITE || state_reg == BK_COPY_WR)
            begin
                if (cmd_reg.two_d && j_reg != cmd_reg.len - 8'd1)
                    j_reg <= j_reg + 8'd1;
                else
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 8'd1;
                end
            end
        end
    end

endmodule
